/* src/ffrf_pkg.sv */
// Shared types and constants of the FASTA / FASTQ record filter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ffrf_pkg;

   // Byte values
   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [7:0] HEADER_BYTE  = 8'h3E;

   // Input operation codes (req_tuser)
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_EOF  = 1'b1;

   // Result kinds (rsp_tuser)
   localparam logic KIND_RECORD  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Configuration register indexes
   localparam logic CSR_FASTQ_MODE = 1'b0;
   localparam logic CSR_MIN_LENGTH = 1'b1;

   localparam logic [31:0] MIN_LENGTH_RESET = 32'd1;
   localparam logic [31:0] COUNT_ONES       = 32'hFFFF_FFFF;

   // Result queue geometry
   localparam int unsigned QUEUE_DEPTH = 2;

   // One queue entry: a record report, a summary, or both (record first).
   // The running totals are shared, since the summary follows the close.
   typedef struct packed {
      logic        has_record;
      logic        has_summary;
      logic [31:0] record_index;
      logic [31:0] record_length;
      logic [31:0] record_count;
      logic [31:0] longest_length;
      logic [47:0] length_sum;
   } entry_type;

endpackage

`default_nettype wire

/* src/fasta_fastq_record_filter.sv */
// Top level of the FASTA / FASTQ record filter: parser core and result queue.
// Depends on ffrf_pkg, ffrf_core and ffrf_outq.
// A result is written into the result queue when the item that causes it is accepted.
// Throughput: one item per cycle while the two-entry result queue has room.
// End of file closing a record: one entry leaves as two items, record then summary.
// Reset (synchronous): parser state and totals cleared, fastq_mode 0, min_length 1.
`default_nettype none

module fasta_fastq_record_filter #(
   parameter int unsigned LEN_BITS = 32,  // width of pending and longest length
   parameter int unsigned SUM_BITS = 48   // width of the saturating length total
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // Item input
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // [7:0] data_byte
   input  wire logic         req_tuser,   // [0] operation
   // Result output
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [175:0]      rsp_tdata,   // [31:0] record_index, [63:32] record_length,
                                          // [95:64] record_count,
                                          // [127:96] longest_length,
                                          // [175:128] length_sum
   output logic              rsp_tuser,   // [0] kind
   output logic              rsp_tlast,   // final_flag
   // Configuration writes
   input  wire logic         csr_wr_en,
   input  wire logic         csr_index,
   input  wire logic [31:0]  csr_wdata
);
   import ffrf_pkg::*;

   logic      item_accept;
   logic      push;
   entry_type entry;
   logic      queue_ready;

   // Accept whenever the queue has a free entry; the parser never stalls.
   assign req_tready  = queue_ready;
   assign item_accept = req_tvalid && req_tready;

   // Parse the byte, close records and keep the running totals.
   ffrf_core #(
      .LEN_BITS (LEN_BITS),
      .SUM_BITS (SUM_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .item_accept (item_accept),
      .item_op     (req_tuser),
      .item_byte   (req_tdata),
      .push_o      (push),
      .entry_o     (entry)
   );

   // Hold results until taken; a combined entry leaves as record, then summary.
   ffrf_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_i     (push),
      .entry_i    (entry),
      .ready_o    (queue_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

/* src/ffrf_core.sv */
// Line parser, record close logic and configuration registers.
// Depends on ffrf_pkg; produces one queue entry per item that yields results.
`default_nettype none

module ffrf_core #(
   parameter int unsigned LEN_BITS = 32,
   parameter int unsigned SUM_BITS = 48
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic                csr_index,
   input  wire logic [31:0]         csr_wdata,
   input  wire logic                item_accept,
   input  wire logic                item_op,
   input  wire logic [7:0]          item_byte,
   output logic                     push_o,
   output ffrf_pkg::entry_type      entry_o
);
   import ffrf_pkg::*;

   localparam int unsigned CMP_BITS = (LEN_BITS > 32) ? LEN_BITS : 32;
   localparam int unsigned ADD_BITS = ((SUM_BITS > LEN_BITS) ? SUM_BITS : LEN_BITS) + 1;
   localparam logic [LEN_BITS-1:0] LEN_ONES = {LEN_BITS{1'b1}};
   localparam logic [SUM_BITS-1:0] SUM_ONES = {SUM_BITS{1'b1}};

   logic                fastq_mode_ff;
   logic [31:0]         min_length_ff;

   logic                at_line_start_ff, at_line_start_in;
   logic [1:0]          line_phase_ff, line_phase_in;
   logic                line_counts_ff, line_counts_in;
   logic                in_sequence_ff, in_sequence_in;
   logic                record_open_ff, record_open_in;
   logic [LEN_BITS-1:0] pending_length_ff, pending_length_in;
   logic [31:0]         accepted_count_ff, accepted_count_in;
   logic [LEN_BITS-1:0] max_seen_ff, max_seen_in;
   logic [SUM_BITS-1:0] total_seen_ff, total_seen_in;

   logic                header;
   logic                close_ok;
   logic                do_close;
   logic [31:0]         count_closed;
   logic [LEN_BITS-1:0] max_closed;
   logic [ADD_BITS-1:0] sum_wide;
   logic [SUM_BITS-1:0] total_closed;
   logic [31:0]         count_post;
   logic [LEN_BITS-1:0] max_post;
   logic [SUM_BITS-1:0] total_post;
   logic                counts_now;
   logic [LEN_BITS-1:0] pending_base;
   logic [63:0]         pending_ext;
   logic [63:0]         max_ext;
   logic [63:0]         total_ext;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fastq_mode_ff <= 1'b0;
         min_length_ff <= MIN_LENGTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FASTQ_MODE: fastq_mode_ff <= csr_wdata[0];
            CSR_MIN_LENGTH: min_length_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Header test and record close
   always_comb begin
      header   = fastq_mode_ff ? (line_phase_ff == 2'd0) : (item_byte == HEADER_BYTE);
      close_ok = record_open_ff &&
                 (CMP_BITS'(pending_length_ff) >= CMP_BITS'(min_length_ff));
      do_close = (item_op == OP_EOF) ? close_ok : (at_line_start_ff && header && close_ok);

      count_closed = (accepted_count_ff == COUNT_ONES) ? accepted_count_ff
                                                       : accepted_count_ff + 32'd1;
      max_closed   = (pending_length_ff > max_seen_ff) ? pending_length_ff : max_seen_ff;
      sum_wide     = ADD_BITS'(total_seen_ff) + ADD_BITS'(pending_length_ff);
      total_closed = (sum_wide[ADD_BITS-1:SUM_BITS] != '0) ? SUM_ONES
                                                           : sum_wide[SUM_BITS-1:0];

      count_post = do_close ? count_closed : accepted_count_ff;
      max_post   = do_close ? max_closed   : max_seen_ff;
      total_post = do_close ? total_closed : total_seen_ff;

      pending_ext = 64'(pending_length_ff);
      max_ext     = 64'(max_post);
      total_ext   = 64'(total_post);

      entry_o.has_record     = do_close;
      entry_o.has_summary    = (item_op == OP_EOF);
      entry_o.record_index   = count_closed;
      entry_o.record_length  = pending_ext[31:0];
      entry_o.record_count   = count_post;
      entry_o.longest_length = max_ext[31:0];
      entry_o.length_sum     = total_ext[47:0];

      push_o = item_accept && (do_close || (item_op == OP_EOF));
   end

   // Next parser state
   always_comb begin
      at_line_start_in  = at_line_start_ff;
      line_phase_in     = line_phase_ff;
      line_counts_in    = line_counts_ff;
      in_sequence_in    = in_sequence_ff;
      record_open_in    = record_open_ff;
      pending_length_in = pending_length_ff;
      accepted_count_in = accepted_count_ff;
      max_seen_in       = max_seen_ff;
      total_seen_in     = total_seen_ff;
      counts_now        = line_counts_ff;
      pending_base      = pending_length_ff;

      if (item_accept) begin
         if (item_op == OP_EOF) begin
            // close done above; start over for the next file
            at_line_start_in  = 1'b1;
            line_phase_in     = 2'd0;
            line_counts_in    = 1'b0;
            in_sequence_in    = 1'b0;
            record_open_in    = 1'b0;
            pending_length_in = '0;
            accepted_count_in = '0;
            max_seen_in       = '0;
            total_seen_in     = '0;
         end else begin
            accepted_count_in = count_post;
            max_seen_in       = max_post;
            total_seen_in     = total_post;
            if (at_line_start_ff) begin
               at_line_start_in = 1'b0;
               if (header) begin
                  record_open_in = 1'b1;
                  pending_base   = '0;
                  in_sequence_in = 1'b1;
                  counts_now     = 1'b0;
               end else begin
                  counts_now = in_sequence_ff;
                  if (fastq_mode_ff) begin
                     in_sequence_in = 1'b0;
                  end
               end
               line_counts_in = counts_now;
            end
            pending_length_in = pending_base;
            if (item_byte == NEWLINE_BYTE) begin
               at_line_start_in = 1'b1;
               line_phase_in    = line_phase_ff + 2'd1;
            end else if (counts_now && (pending_base != LEN_ONES)) begin
               pending_length_in = pending_base + LEN_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff  <= 1'b1;
         line_phase_ff     <= 2'd0;
         line_counts_ff    <= 1'b0;
         in_sequence_ff    <= 1'b0;
         record_open_ff    <= 1'b0;
         pending_length_ff <= '0;
         accepted_count_ff <= '0;
         max_seen_ff       <= '0;
         total_seen_ff     <= '0;
      end else begin
         at_line_start_ff  <= at_line_start_in;
         line_phase_ff     <= line_phase_in;
         line_counts_ff    <= line_counts_in;
         in_sequence_ff    <= in_sequence_in;
         record_open_ff    <= record_open_in;
         pending_length_ff <= pending_length_in;
         accepted_count_ff <= accepted_count_in;
         max_seen_ff       <= max_seen_in;
         total_seen_ff     <= total_seen_in;
      end
   end

endmodule

`default_nettype wire

/* src/ffrf_outq.sv */
// Two-entry result queue; splits an entry holding a record and a summary
// into two items. Depends on ffrf_pkg.
`default_nettype none

module ffrf_outq (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_i,
   input  wire ffrf_pkg::entry_type entry_i,
   output logic                     ready_o,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [175:0]             rsp_tdata,
   output logic                     rsp_tuser,
   output logic                     rsp_tlast
);
   import ffrf_pkg::*;

   entry_type   mem_ff [QUEUE_DEPTH];
   logic        head_ff, head_in;
   logic        tail_ff, tail_in;
   logic [1:0]  count_ff, count_in;
   logic        sub_ff, sub_in;
   entry_type   head_entry;
   logic        show_record;
   logic        pop;
   logic        last_part;
   logic [31:0] out_index;
   logic [31:0] out_length;

   always_comb begin
      head_entry  = mem_ff[head_ff];
      ready_o     = (count_ff != 2'(QUEUE_DEPTH));
      rsp_tvalid  = (count_ff != 2'd0);
      show_record = head_entry.has_record && !sub_ff;
      out_index   = show_record ? head_entry.record_index  : 32'd0;
      out_length  = show_record ? head_entry.record_length : 32'd0;
      rsp_tuser   = show_record ? KIND_RECORD : KIND_SUMMARY;
      rsp_tlast   = show_record ? !head_entry.has_summary : 1'b1;
      rsp_tdata   = {head_entry.length_sum, head_entry.longest_length,
                     head_entry.record_count, out_length, out_index};

      pop       = rsp_tvalid && rsp_tready;
      last_part = !(show_record && head_entry.has_summary);

      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      sub_in   = sub_ff;
      if (pop) begin
         if (last_part) begin
            head_in = head_ff + 1'b1;
            sub_in  = 1'b0;
         end else begin
            sub_in = 1'b1;
         end
      end
      if (push_i) begin
         tail_in = tail_ff + 1'b1;
      end
      count_in = count_ff + 2'(push_i) - 2'(pop && last_part);
   end

   always_ff @(posedge clock) begin
      if (push_i) begin
         mem_ff[tail_ff] <= entry_i;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
         sub_ff   <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         sub_ff   <= sub_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_i |-> (count_ff != 2'(QUEUE_DEPTH)))
      else $error("result pushed into a full queue");

   a_entry_nonempty: assert property (@(posedge clock) disable iff (reset)
      push_i |-> (entry_i.has_record || entry_i.has_summary))
      else $error("queue entry carries no item");

   a_summary_follows: assert property (@(posedge clock) disable iff (reset)
      (pop && !last_part) |=> (rsp_tvalid && rsp_tuser == KIND_SUMMARY && rsp_tlast))
      else $error("summary did not follow its record report");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

endmodule

`default_nettype wire
